// File: rtl/core/dag_reach_filtered_max_query_assert.svh
// Assertion macros shared by the checker of the reachability query block.
`ifndef DAG_REACH_FILTERED_MAX_QUERY_ASSERT_SVH
`define DAG_REACH_FILTERED_MAX_QUERY_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drq check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define DRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drq check failed: next-cycle implication");

`endif

// File: rtl/core/drq_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package drq_pkg;

    localparam int DRQ_MAX_NODES  = 64;
    localparam int DRQ_VALUE_BITS = 32;

    localparam int NODE_W  = 6;
    localparam int COUNT_W = 7;
    localparam int REQ_W   = 3;
    localparam int BOUND_W = 32;
    localparam int OUT_W   = 31;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
    localparam logic [ADDR_W-1:0]  REG_NODE_COUNT = 2'd0;

    typedef enum logic [REQ_W-1:0] {
        REQ_EDGE      = 3'd0,
        REQ_BUILD     = 3'd1,
        REQ_LD_FIRST  = 3'd2,
        REQ_LD_SECOND = 3'd3,
        REQ_SW_FIRST  = 3'd4,
        REQ_SW_SECOND = 3'd5,
        REQ_QUERY     = 3'd6,
        REQ_CLEAR     = 3'd7
    } t_req;

    typedef struct packed {
        logic cap;
        logic clr_row0;
        logic clr_wr;
        logic row_inc;
        logic row_top;
        logic row_dec;
        logic edge_rd;
        logic edge_wr;
        logic ld_val;
        logic sw_rd_a;
        logic sw_rd_b;
        logic sw_wr_a;
        logic sw_wr_b;
        logic bld_zero_wr;
        logic bld_start;
        logic scan_issue;
        logic bld_wr;
        logic q_start;
        logic q_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic a_ok;
        logic b_ok;
        logic row_end;
        logic row_zero;
        logic row_live;
        logic col_live;
        logic out_full;
    } t_stat;

endpackage

// File: rtl/core/drq_ctrl.sv
// Sequencing state machine for the reachability query block.
module drq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  drq_pkg::t_stat i_stat,
    output drq_pkg::t_cmd  o_cmd,
    output logic          o_idle
);
    import drq_pkg::*;

    typedef enum logic [11:0] {
        S_CLR      = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_DISP     = 12'b000000000100,
        S_EDGE_WR  = 12'b000000001000,
        S_SW_RB    = 12'b000000010000,
        S_SW_WA    = 12'b000000100000,
        S_SW_WB    = 12'b000001000000,
        S_BLD_ROW  = 12'b000010000000,
        S_BLD_SCAN = 12'b000100000000,
        S_BLD_WR   = 12'b001000000000,
        S_Q_SCAN   = 12'b010000000000,
        S_Q_OUT    = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.row_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.row_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_IDLE;
                unique case (i_stat.req)
                    REQ_EDGE: begin
                        if (i_stat.a_ok && i_stat.b_ok) begin
                            o_cmd.edge_rd = 1'b1;
                            n_state       = S_EDGE_WR;
                        end
                    end
                    REQ_BUILD: begin
                        o_cmd.row_top = 1'b1;
                        n_state       = S_BLD_ROW;
                    end
                    REQ_LD_FIRST, REQ_LD_SECOND: begin
                        o_cmd.ld_val = i_stat.a_ok;
                    end
                    REQ_SW_FIRST, REQ_SW_SECOND: begin
                        if (i_stat.a_ok && i_stat.b_ok) begin
                            o_cmd.sw_rd_a = 1'b1;
                            n_state       = S_SW_RB;
                        end
                    end
                    REQ_QUERY: begin
                        if (i_stat.a_ok) begin
                            o_cmd.q_start = 1'b1;
                            n_state       = S_Q_SCAN;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.clr_row0 = 1'b1;
                        n_state        = S_CLR;
                    end
                endcase
            end
            S_EDGE_WR: begin
                o_cmd.edge_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_SW_RB: begin
                o_cmd.sw_rd_b = 1'b1;
                n_state       = S_SW_WA;
            end
            S_SW_WA: begin
                o_cmd.sw_wr_a = 1'b1;
                n_state       = S_SW_WB;
            end
            S_SW_WB: begin
                o_cmd.sw_wr_b = 1'b1;
                n_state       = S_IDLE;
            end
            S_BLD_ROW: begin
                if (!i_stat.row_live) begin
                    o_cmd.bld_zero_wr = 1'b1;
                    if (i_stat.row_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.row_dec = 1'b1;
                    end
                end else begin
                    o_cmd.bld_start = 1'b1;
                    n_state         = S_BLD_SCAN;
                end
            end
            S_BLD_SCAN: begin
                if (i_stat.col_live) begin
                    o_cmd.scan_issue = 1'b1;
                end else begin
                    n_state = S_BLD_WR;
                end
            end
            S_BLD_WR: begin
                o_cmd.bld_wr = 1'b1;
                if (i_stat.row_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.row_dec = 1'b1;
                    n_state       = S_BLD_ROW;
                end
            end
            S_Q_SCAN: begin
                if (i_stat.col_live) begin
                    o_cmd.q_issue = 1'b1;
                end else begin
                    n_state = S_Q_OUT;
                end
            end
            S_Q_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// File: rtl/core/drq_dpath.sv
// Datapath: graph memories, row and column counters, accumulators, result register.
module drq_dpath #(
    parameter int MAX_NODES  = drq_pkg::DRQ_MAX_NODES,
    parameter int VALUE_BITS = drq_pkg::DRQ_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  drq_pkg::t_cmd                      i_cmd,
    input  logic [drq_pkg::REQ_W-1:0]          i_req_type,
    input  logic [drq_pkg::NODE_W-1:0]         i_node_a,
    input  logic [drq_pkg::NODE_W-1:0]         i_node_b,
    input  logic signed [drq_pkg::BOUND_W-1:0] i_value_or_low,
    input  logic signed [drq_pkg::BOUND_W-1:0] i_upper_bound,
    input  logic [drq_pkg::COUNT_W-1:0]        i_node_limit,
    input  logic                              i_out_stall,
    output drq_pkg::t_stat                     o_stat,
    output logic                              o_out_valid,
    output logic [drq_pkg::OUT_W-1:0]          o_best_value
);
    import drq_pkg::*;

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CMP_W = (VALUE_BITS > BOUND_W) ? VALUE_BITS : BOUND_W;
    localparam logic [AW-1:0] ROW_LAST = AW'(MAX_NODES - 1);
    localparam logic [MAX_NODES-1:0] ONE_BIT = MAX_NODES'(1);

    // Captured request.
    t_req                       r_type;
    logic [NODE_W-1:0]          r_a;
    logic [NODE_W-1:0]          r_b;
    logic signed [BOUND_W-1:0]  r_lo;
    logic signed [BOUND_W-1:0]  r_hi;

    // Memories and their registered read data.
    logic [MAX_NODES-1:0]         r_adj_mem    [MAX_NODES];
    logic [MAX_NODES-1:0]         r_reach_mem  [MAX_NODES];
    logic signed [VALUE_BITS-1:0] r_first_mem  [MAX_NODES];
    logic signed [VALUE_BITS-1:0] r_second_mem [MAX_NODES];
    logic [MAX_NODES-1:0]         r_adj_q;
    logic [MAX_NODES-1:0]         r_reach_q;
    logic signed [VALUE_BITS-1:0] r_first_q;
    logic signed [VALUE_BITS-1:0] r_second_q;

    logic [AW-1:0]                r_row;
    logic [AW:0]                  r_col;
    logic                         r_pend;
    logic [AW-1:0]                r_pidx;
    logic [MAX_NODES-1:0]         r_acc;
    logic signed [VALUE_BITS-1:0] r_best;
    logic signed [VALUE_BITS-1:0] r_tmp;
    logic                         r_out_valid;
    logic [OUT_W-1:0]             r_out;

    logic                         adj_we, reach_we, first_we, second_we;
    logic                         adj_re, reach_re, val_re;
    logic [AW-1:0]                adj_wa, reach_wa, val_wa;
    logic [AW-1:0]                adj_ra, reach_ra, val_ra;
    logic [MAX_NODES-1:0]         adj_wd, reach_wd;
    logic signed [VALUE_BITS-1:0] val_wd;

    logic [AW-1:0]                a_idx, b_idx;
    logic                         sw_first, bld_mode, in_range;
    logic signed [VALUE_BITS-1:0] lo_fit;
    logic signed [CMP_W-1:0]      first_ext, lo_ext, hi_ext;
    logic [63:0]                  best_wide;

    assign a_idx     = AW'(r_a);
    assign b_idx     = AW'(r_b);
    assign sw_first  = (r_type == REQ_SW_FIRST);
    assign bld_mode  = (r_type == REQ_BUILD);
    assign lo_fit    = VALUE_BITS'(r_lo);
    assign first_ext = CMP_W'(r_first_q);
    assign lo_ext    = CMP_W'(r_lo);
    assign hi_ext    = CMP_W'(r_hi);
    assign in_range  = (first_ext >= lo_ext) && (first_ext <= hi_ext);
    assign best_wide = 64'(r_best);

    always_comb begin
        adj_we    = 1'b0;
        reach_we  = 1'b0;
        first_we  = 1'b0;
        second_we = 1'b0;
        adj_wa    = r_row;
        reach_wa  = r_row;
        val_wa    = r_row;
        adj_wd    = '0;
        reach_wd  = '0;
        val_wd    = '0;
        adj_re    = 1'b0;
        reach_re  = 1'b0;
        val_re    = 1'b0;
        adj_ra    = r_row;
        reach_ra  = a_idx;
        val_ra    = a_idx;
        if (i_cmd.clr_wr) begin
            adj_we    = 1'b1;
            reach_we  = 1'b1;
            first_we  = 1'b1;
            second_we = 1'b1;
        end
        if (i_cmd.edge_rd) begin
            adj_re = 1'b1;
            adj_ra = a_idx;
        end
        if (i_cmd.edge_wr) begin
            adj_we = 1'b1;
            adj_wa = a_idx;
            adj_wd = r_adj_q | (ONE_BIT << b_idx);
        end
        if (i_cmd.ld_val) begin
            first_we  = (r_type == REQ_LD_FIRST);
            second_we = (r_type == REQ_LD_SECOND);
            val_wa    = a_idx;
            val_wd    = lo_fit;
        end
        if (i_cmd.sw_rd_a) begin
            val_re = 1'b1;
        end
        if (i_cmd.sw_rd_b) begin
            val_re = 1'b1;
            val_ra = b_idx;
        end
        if (i_cmd.sw_wr_a) begin
            first_we  = sw_first;
            second_we = !sw_first;
            val_wa    = a_idx;
            val_wd    = sw_first ? r_first_q : r_second_q;
        end
        if (i_cmd.sw_wr_b) begin
            first_we  = sw_first;
            second_we = !sw_first;
            val_wa    = b_idx;
            val_wd    = r_tmp;
        end
        if (i_cmd.bld_zero_wr) begin
            reach_we = 1'b1;
        end
        if (i_cmd.bld_start) begin
            adj_re = 1'b1;
        end
        if (i_cmd.scan_issue) begin
            reach_re = 1'b1;
            reach_ra = r_col[AW-1:0];
        end
        if (i_cmd.bld_wr) begin
            reach_we = 1'b1;
            reach_wd = r_acc;
        end
        if (i_cmd.q_start) begin
            reach_re = 1'b1;
        end
        if (i_cmd.q_issue) begin
            val_re = 1'b1;
            val_ra = r_col[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[adj_wa] <= adj_wd;
        end
        if (adj_re) begin
            r_adj_q <= r_adj_mem[adj_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (reach_we) begin
            r_reach_mem[reach_wa] <= reach_wd;
        end
        if (reach_re) begin
            r_reach_q <= r_reach_mem[reach_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (first_we) begin
            r_first_mem[val_wa] <= val_wd;
        end
        if (val_re) begin
            r_first_q <= r_first_mem[val_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (second_we) begin
            r_second_mem[val_wa] <= val_wd;
        end
        if (val_re) begin
            r_second_q <= r_second_mem[val_ra];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_type <= t_req'(i_req_type);
            r_a    <= i_node_a;
            r_b    <= i_node_b;
            r_lo   <= i_value_or_low;
            r_hi   <= i_upper_bound;
        end
        if (i_cmd.bld_start) begin
            r_col <= (AW + 1)'(r_row) + 1'b1;
        end else if (i_cmd.q_start) begin
            r_col <= '0;
        end else if (i_cmd.scan_issue || i_cmd.q_issue) begin
            r_col <= r_col + 1'b1;
        end
        r_pidx <= r_col[AW-1:0];
        if (i_cmd.bld_start) begin
            r_acc <= ONE_BIT << r_row;
        end else if (r_pend && bld_mode && r_adj_q[r_pidx]) begin
            r_acc <= r_acc | r_reach_q;
        end
        if (i_cmd.q_start) begin
            r_best <= '0;
        end else if (r_pend && !bld_mode && r_reach_q[r_pidx] && in_range &&
                     (r_second_q > r_best)) begin
            r_best <= r_second_q;
        end
        if (i_cmd.sw_rd_b) begin
            r_tmp <= sw_first ? r_first_q : r_second_q;
        end
        if (i_cmd.out_load) begin
            r_out <= best_wide[OUT_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_row0) begin
                r_row <= '0;
            end else if (i_cmd.row_top) begin
                r_row <= ROW_LAST;
            end else if (i_cmd.row_inc) begin
                r_row <= r_row + 1'b1;
            end else if (i_cmd.row_dec) begin
                r_row <= r_row - 1'b1;
            end
            r_pend <= i_cmd.scan_issue || i_cmd.q_issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req      = r_type;
    assign o_stat.a_ok     = 32'(r_a) < 32'(i_node_limit);
    assign o_stat.b_ok     = 32'(r_b) < 32'(i_node_limit);
    assign o_stat.row_end  = (r_row == ROW_LAST);
    assign o_stat.row_zero = (r_row == '0);
    assign o_stat.row_live = 32'(r_row) < 32'(i_node_limit);
    assign o_stat.col_live = 32'(r_col) < 32'(i_node_limit);
    assign o_stat.out_full = r_out_valid;

    assign o_out_valid  = r_out_valid;
    assign o_best_value = r_out;

endmodule

// File: rtl/core/dag_reach_filtered_max_query.sv
// Top level of the graph reachability and filtered maximum query block.
//
//   Channel   Direction  Handshake             Payload
//   request   in         i_valid / o_stall     i_req_type, i_node_a, i_node_b,
//                                              i_value_or_low, i_upper_bound
//   result    out        o_valid / i_stall     o_best_value
//   config    in         psel/penable/pready   paddr, pwdata, prdata
//
// One request is worked at a time; its length is set by the sequencer walking the
// graph memories and grows with the number of live nodes for a query and for a
// closure build, which reads one memory row per cycle. After reset a clearing
// pass zeroes all memories; o_stall stays high until it is done. Configuration
// writes are taken at any time. A query result waits in an output register
// while i_stall is high; a new request is still taken, and only a later query
// waits for that register.
module dag_reach_filtered_max_query #(
    parameter int MAX_NODES  = drq_pkg::DRQ_MAX_NODES,
    parameter int VALUE_BITS = drq_pkg::DRQ_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [drq_pkg::REQ_W-1:0]          i_req_type,
    input  logic [drq_pkg::NODE_W-1:0]         i_node_a,
    input  logic [drq_pkg::NODE_W-1:0]         i_node_b,
    input  logic signed [drq_pkg::BOUND_W-1:0] i_value_or_low,
    input  logic signed [drq_pkg::BOUND_W-1:0] i_upper_bound,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [drq_pkg::OUT_W-1:0]          o_best_value,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [drq_pkg::ADDR_W-1:0]         paddr,
    input  logic [drq_pkg::DATA_W-1:0]         pwdata,
    output logic [drq_pkg::DATA_W-1:0]         prdata,
    output logic                              pready
);
    import drq_pkg::*;

    logic [COUNT_W-1:0] r_node_count;
    logic [COUNT_W-1:0] node_limit;
    logic               idle;
    t_cmd               cmd;
    t_stat              stat;

    // The node count register; writes land in the access phase of a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_NODE_COUNT)) begin
            r_node_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_NODE_COUNT) ? DATA_W'(r_node_count) : '0;

    // A count above the memory depth behaves as the full depth.
    assign node_limit = (32'(r_node_count) > MAX_NODES) ? COUNT_W'(MAX_NODES)
                                                       : r_node_count;

    // New requests are taken only while the sequencer sits idle.
    assign o_stall = !idle;

    drq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    drq_dpath #(
        .MAX_NODES  (MAX_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_value_or_low (i_value_or_low),
        .i_upper_bound  (i_upper_bound),
        .i_node_limit   (node_limit),
        .i_out_stall    (i_stall),
        .o_stat         (stat),
        .o_out_valid    (o_valid),
        .o_best_value   (o_best_value)
    );

endmodule

// File: rtl/core/drq_checker.sv
// Port-level checker for the reachability query block and its bind.
`include "dag_reach_filtered_max_query_assert.svh"

module drq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [drq_pkg::OUT_W-1:0]          o_best_value,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [drq_pkg::ADDR_W-1:0]         paddr,
    input logic [drq_pkg::DATA_W-1:0]         pwdata,
    input logic [drq_pkg::DATA_W-1:0]         prdata
);
    import drq_pkg::*;

    // A held result keeps its value until taken.
    `DRQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_best_value))

    // Taking a request always makes the block busy in the next cycle.
    `DRQ_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // A result only appears as the end of work that kept the input stalled.
    `DRQ_ASSERT_IMP(a_out_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

    // A node count write reads back on the next cycle.
    `DRQ_ASSERT_NXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && (paddr == REG_NODE_COUNT), prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))

endmodule

bind dag_reach_filtered_max_query drq_checker u_drq_checker (.*);
